// ===== rtl/fenp_pkg.sv =====
package fenp_pkg;

   // number of boards and their slots in the board store
   localparam int unsigned NUM_BOARDS = 9;
   localparam int unsigned BD_OCC     = 0;
   localparam int unsigned BD_TYPE0   = 1;
   localparam int unsigned BD_WHITE   = 7;
   localparam int unsigned BD_BLACK   = 8;

   // result status codes
   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_END         = 4'd1,
      ST_BAD_SKIP    = 4'd2,
      ST_FILE_OVF    = 4'd3,
      ST_EARLY_SLASH = 4'd4,
      ST_BAD_PIECE   = 4'd5,
      ST_OUTSIDE     = 4'd6,
      ST_NOT_8X8     = 4'd7,
      ST_BAD_SIDE    = 4'd8
   } status_type;

   // character classes as seen in the board field
   typedef enum logic [2:0] {
      CLS_BLANK,
      CLS_SKIP,
      CLS_BAD_SKIP,
      CLS_SLASH,
      CLS_PIECE,
      CLS_OTHER
   } cls_type;

   // piece kinds, in board store order after the occupancy board
   typedef enum logic [2:0] {
      PC_PAWN,
      PC_KNIGHT,
      PC_BISHOP,
      PC_ROOK,
      PC_QUEEN,
      PC_KING
   } piece_type;

   // one classified character, front to back
   typedef struct packed {
      cls_type   cls;
      logic [3:0] skip;
      piece_type piece;
      logic      black;
      logic      side_w;
      logic      side_b;
      logic      first;
      logic      last;
   } cmd_type;

   // one result item
   typedef struct packed {
      status_type                     status;
      logic                           side;
      logic [NUM_BOARDS-1:0][63:0]    boards;
   } res_type;

endpackage

// ===== rtl/fen_placement_to_bitboards.sv =====
// Position-record parser: one ASCII character is taken per clock, sustained,
// whenever the result side keeps up. A character passes a classifier register,
// a small queue (QUEUE_DEPTH entries) and the parse stage, which writes the
// result register. At most one result per record: on the side-to-move letter,
// on the first error, or on the last character of an unfinished record. The
// nine boards use square = rank*8 + file with a1 as bit 0. Characters outside
// a record are dropped until a character flagged as first arrives.
module fen_placement_to_bitboards import fenp_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_first_char,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic        rsp_side_to_move,
   output logic [63:0] rsp_occupied_board,
   output logic [63:0] rsp_pawn_board,
   output logic [63:0] rsp_knight_board,
   output logic [63:0] rsp_bishop_board,
   output logic [63:0] rsp_rook_board,
   output logic [63:0] rsp_queen_board,
   output logic [63:0] rsp_king_board,
   output logic [63:0] rsp_white_board,
   output logic [63:0] rsp_black_board
);

   logic    f_valid, f_ready, q_valid, q_ready;
   cmd_type f_cmd, q_cmd;
   res_type res;

   // classifier front end
   fenp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .req_first_char (req_first_char),
      .req_last_char  (req_last_char),
      .cmd_valid      (f_valid),
      .cmd_ready      (f_ready),
      .cmd            (f_cmd)
   );

   // decoupling queue
   fenp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   // parse stage and result register
   fenp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .res       (res)
   );

   assign rsp_status         = res.status;
   assign rsp_side_to_move   = res.side;
   assign rsp_occupied_board = res.boards[BD_OCC];
   assign rsp_pawn_board     = res.boards[BD_TYPE0 + 0];
   assign rsp_knight_board   = res.boards[BD_TYPE0 + 1];
   assign rsp_bishop_board   = res.boards[BD_TYPE0 + 2];
   assign rsp_rook_board     = res.boards[BD_TYPE0 + 3];
   assign rsp_queen_board    = res.boards[BD_TYPE0 + 4];
   assign rsp_king_board     = res.boards[BD_TYPE0 + 5];
   assign rsp_white_board    = res.boards[BD_WHITE];
   assign rsp_black_board    = res.boards[BD_BLACK];

endmodule

// ===== rtl/fenp_front.sv =====
module fenp_front import fenp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_first_char,
   input  logic       req_last_char,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;

   assign req_ready = !valid_ff || cmd_ready;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   // classify the character; no parse state is needed here
   always_comb begin
      cmd_in        = '0;
      cmd_in.cls    = CLS_OTHER;
      cmd_in.piece  = PC_PAWN;
      cmd_in.first  = req_first_char;
      cmd_in.last   = req_last_char;
      cmd_in.side_w = (req_char_code == "w");
      cmd_in.side_b = (req_char_code == "b");
      cmd_in.skip   = req_char_code[3:0];
      if (req_char_code == 8'd32 || req_char_code inside {[8'd9:8'd13]}) begin
         cmd_in.cls = CLS_BLANK;
      end else if (req_char_code inside {["1":"8"]}) begin
         cmd_in.cls = CLS_SKIP;
      end else if (req_char_code == "0" || req_char_code == "9") begin
         cmd_in.cls = CLS_BAD_SKIP;
      end else if (req_char_code == "/") begin
         cmd_in.cls = CLS_SLASH;
      end else begin
         cmd_in.cls = CLS_PIECE;
         case (req_char_code)
            "P": begin cmd_in.piece = PC_PAWN;   cmd_in.black = 1'b0; end
            "N": begin cmd_in.piece = PC_KNIGHT; cmd_in.black = 1'b0; end
            "B": begin cmd_in.piece = PC_BISHOP; cmd_in.black = 1'b0; end
            "R": begin cmd_in.piece = PC_ROOK;   cmd_in.black = 1'b0; end
            "Q": begin cmd_in.piece = PC_QUEEN;  cmd_in.black = 1'b0; end
            "K": begin cmd_in.piece = PC_KING;   cmd_in.black = 1'b0; end
            "p": begin cmd_in.piece = PC_PAWN;   cmd_in.black = 1'b1; end
            "n": begin cmd_in.piece = PC_KNIGHT; cmd_in.black = 1'b1; end
            "b": begin cmd_in.piece = PC_BISHOP; cmd_in.black = 1'b1; end
            "r": begin cmd_in.piece = PC_ROOK;   cmd_in.black = 1'b1; end
            "q": begin cmd_in.piece = PC_QUEEN;  cmd_in.black = 1'b1; end
            "k": begin cmd_in.piece = PC_KING;   cmd_in.black = 1'b1; end
            default: cmd_in.cls = CLS_OTHER;
         endcase
      end
   end

   // pipeline register toward the queue
   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ===== rtl/fenp_queue.sv =====
module fenp_queue import fenp_pkg::*; #(
   parameter int unsigned DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   cmd_type       slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          push, pop;

   assign in_ready  = (cnt_ff != FULL_CNT);
   assign out_valid = (cnt_ff != '0);
   assign out_cmd   = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_SLOT) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_SLOT) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= in_cmd;
      end
   end

endmodule

// ===== rtl/fenp_back.sv =====
module fenp_back import fenp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output res_type res
);

   typedef enum logic [1:0] {
      PH_DONE,
      PH_BOARD,
      PH_SIDE
   } phase_type;

   localparam logic [3:0] RANK_TOP   = 4'd7;
   localparam logic [3:0] RANK_FLOOR = 4'hF;
   localparam logic [3:0] FILE_END   = 4'd8;

   phase_type                   phase_ff, phase_in, phase_w;
   logic [3:0]                  file_ff, file_in, file_w;
   logic [3:0]                  rank_ff, rank_in, rank_w;
   logic [NUM_BOARDS-1:0][63:0] board_ff, board_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   res_type                     res_ff, res_in;
   logic                        pop, emit, err;
   status_type                  st;
   logic                        side;
   logic [4:0]                  file_sum;
   logic [63:0]                 sq_bit;
   logic [3:0]                  type_sel;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = cmd_valid && cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign res       = res_ff;
   assign file_sum  = {1'b0, file_w} + {1'b0, cmd.skip};
   assign sq_bit    = 64'd1 << {rank_w[2:0], file_w[2:0]};
   assign type_sel  = 4'(BD_TYPE0) + {1'b0, cmd.piece};

   // execute one classified character against the parse state
   always_comb begin
      phase_w  = cmd.first ? PH_BOARD : phase_ff;
      file_w   = cmd.first ? 4'd0 : file_ff;
      rank_w   = cmd.first ? RANK_TOP : rank_ff;
      board_in = cmd.first ? '0 : board_ff;
      phase_in = phase_w;
      file_in  = file_w;
      rank_in  = rank_w;
      emit     = 1'b0;
      err      = 1'b0;
      st       = ST_OK;
      side     = 1'b0;
      case (phase_w)
         PH_SIDE: begin
            emit = 1'b1;
            if (cmd.side_w || cmd.side_b) begin
               side = cmd.side_b;
            end else begin
               st = ST_BAD_SIDE;
            end
         end
         PH_BOARD: begin
            case (cmd.cls)
               CLS_BLANK: begin
                  if (rank_w != 4'd0 || file_w != FILE_END) begin
                     err = 1'b1;
                     st  = ST_NOT_8X8;
                  end else begin
                     phase_in = PH_SIDE;
                  end
               end
               CLS_SKIP: begin
                  if (file_sum > 5'd8) begin
                     err = 1'b1;
                     st  = ST_FILE_OVF;
                  end else begin
                     file_in = file_sum[3:0];
                  end
               end
               CLS_BAD_SKIP: begin
                  err = 1'b1;
                  st  = ST_BAD_SKIP;
               end
               CLS_SLASH: begin
                  if (file_w < FILE_END) begin
                     err = 1'b1;
                     st  = ST_EARLY_SLASH;
                  end else begin
                     file_in = 4'd0;
                     if (rank_w != RANK_FLOOR) begin
                        rank_in = rank_w - 4'd1;
                     end
                  end
               end
               CLS_PIECE: begin
                  if (file_w >= FILE_END || rank_w[3]) begin
                     err = 1'b1;
                     st  = ST_OUTSIDE;
                  end else begin
                     board_in[BD_OCC]   = board_in[BD_OCC] | sq_bit;
                     board_in[type_sel] = board_in[type_sel] | sq_bit;
                     if (cmd.black) begin
                        board_in[BD_BLACK] = board_in[BD_BLACK] | sq_bit;
                     end else begin
                        board_in[BD_WHITE] = board_in[BD_WHITE] | sq_bit;
                     end
                     file_in = file_w + 4'd1;
                  end
               end
               default: begin
                  err = 1'b1;
                  st  = ST_BAD_PIECE;
               end
            endcase
            emit = err || cmd.last;
            if (!err && cmd.last) begin
               st = ST_END;
            end
         end
         default: begin
         end
      endcase
      if (emit) begin
         phase_in = PH_DONE;
      end
   end

   // result register, freed as soon as the result transfers
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      res_in       = res_ff;
      if (pop && emit) begin
         rsp_valid_in  = 1'b1;
         res_in.status = st;
         res_in.side   = side;
         res_in.boards = board_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DONE;
         file_ff      <= 4'd0;
         rank_ff      <= RANK_TOP;
         board_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            file_ff  <= file_in;
            rank_ff  <= rank_in;
            board_ff <= board_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff <= res_in;
   end

`ifndef SYNTHESIS
   a_file_range: assert property (@(posedge clock) disable iff (reset)
      file_ff <= FILE_END)
      else $error("file position beyond the board edge");

   a_rank_floor: assert property (@(posedge clock) disable iff (reset)
      !rank_ff[3] || rank_ff == RANK_FLOOR)
      else $error("rank position below its floor");

   a_occ_union: assert property (@(posedge clock) disable iff (reset)
      board_ff[BD_OCC] == (board_ff[BD_WHITE] | board_ff[BD_BLACK]))
      else $error("occupancy differs from union of colour boards");

   a_colour_split: assert property (@(posedge clock) disable iff (reset)
      (board_ff[BD_WHITE] & board_ff[BD_BLACK]) == 64'd0)
      else $error("square marked with both colours");

   a_side_ok_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_ff.status != ST_OK) |-> !res_ff.side)
      else $error("side reported on a failed parse");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import fenp_pkg::*;

   // character constants of the record syntax
   localparam logic [7:0] CH_SLASH = "/";
   localparam logic [7:0] CH_ZERO  = "0";
   localparam logic [7:0] CH_NINE  = "9";
   localparam logic [7:0] CH_WHITE = "w";
   localparam logic [7:0] CH_BLACK = "b";
   localparam logic [7:0] CH_SPACE = " ";
   localparam string PIECE_LETTERS = "PNBRQKpnbrqk";

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PLACE,
      PH_SIDE
   } phase_type;

   typedef struct {
      logic [7:0] code;
      logic       first;
      logic       last;
   } char_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = '0;
   logic        req_first_char = 1'b0;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_status;
   logic        rsp_side_to_move;
   logic [63:0] rsp_occupied_board;
   logic [63:0] rsp_pawn_board;
   logic [63:0] rsp_knight_board;
   logic [63:0] rsp_bishop_board;
   logic [63:0] rsp_rook_board;
   logic [63:0] rsp_queen_board;
   logic [63:0] rsp_king_board;
   logic [63:0] rsp_white_board;
   logic [63:0] rsp_black_board;

   fen_placement_to_bitboards dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_code      (req_char_code),
      .req_first_char     (req_first_char),
      .req_last_char      (req_last_char),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_side_to_move   (rsp_side_to_move),
      .rsp_occupied_board (rsp_occupied_board),
      .rsp_pawn_board     (rsp_pawn_board),
      .rsp_knight_board   (rsp_knight_board),
      .rsp_bishop_board   (rsp_bishop_board),
      .rsp_rook_board     (rsp_rook_board),
      .rsp_queen_board    (rsp_queen_board),
      .rsp_king_board     (rsp_king_board),
      .rsp_white_board    (rsp_white_board),
      .rsp_black_board    (rsp_black_board)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   char_item_type char_queue [$];
   res_type  expected_results [$];
   int       sent_count = 0;
   int       record_chars = 0;
   int       record_total = 0;
   int       results_checked = 0;
   int       error_count = 0;
   logic [8:0] status_seen = '0;

   string board_name [NUM_BOARDS] = '{"occupied", "pawn", "knight", "bishop", "rook",
                                      "queen", "king", "white", "black"};

   // parser shadow state
   phase_type                   phase_q = PH_IDLE;
   int                          file_q = 0;
   int                          rank_q = 7;
   logic [NUM_BOARDS-1:0][63:0] board_q = '0;
   logic                        side_q = 1'b0;

   // random idling, except for a calm stretch in the middle of the run
   function automatic bit pause_now();
      return (sent_count < 400 || sent_count >= 700) && ($urandom_range(99) < 37);
   endfunction

   task automatic close_record(input status_type st);
      res_type r;
      r.status = st;
      r.side   = (st == ST_OK) ? side_q : 1'b0;
      r.boards = board_q;
      expected_results.push_back(r);
      status_seen[st] = 1'b1;
      phase_q = PH_IDLE;
   endtask

   // shadow parser: one character in, at most one expected result out
   task automatic parse_char(input logic [7:0] c, input logic first, input logic last);
      int        idx;
      int        sq;
      int        digit;
      bit        found;
      piece_type kind;
      logic      is_black;
      found    = 1'b0;
      kind     = PC_PAWN;
      is_black = 1'b0;
      if (first) begin
         board_q = '0;
         file_q  = 0;
         rank_q  = 7;
         phase_q = PH_PLACE;
      end
      if (phase_q == PH_IDLE) return;
      if (phase_q == PH_SIDE) begin
         if (c == CH_WHITE || c == CH_BLACK) begin
            side_q = (c == CH_BLACK);
            close_record(ST_OK);
         end else begin
            close_record(ST_BAD_SIDE);
         end
         return;
      end
      if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
         if (rank_q != 0 || file_q != 8) begin
            close_record(ST_NOT_8X8);
            return;
         end
         phase_q = PH_SIDE;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         digit = int'(c) - int'(CH_ZERO);
         if (digit < 1 || digit > 8) begin
            close_record(ST_BAD_SKIP);
            return;
         end
         if (file_q + digit > 8) begin
            close_record(ST_FILE_OVF);
            return;
         end
         file_q += digit;
      end else if (c == CH_SLASH) begin
         if (file_q < 8) begin
            close_record(ST_EARLY_SLASH);
            return;
         end
         if (rank_q > -1) rank_q--;
         file_q = 0;
      end else begin
         for (idx = 0; idx < 12; idx++) begin
            if (!found && PIECE_LETTERS[idx] == c) begin
               found    = 1'b1;
               kind     = piece_type'(idx % 6);
               is_black = (idx >= 6);
            end
         end
         if (!found) begin
            close_record(ST_BAD_PIECE);
            return;
         end
         if (file_q >= 8 || rank_q < 0) begin
            close_record(ST_OUTSIDE);
            return;
         end
         sq = rank_q * 8 + file_q;
         board_q[BD_OCC][sq] = 1'b1;
         board_q[BD_TYPE0 + int'(kind)][sq] = 1'b1;
         board_q[is_black ? BD_BLACK : BD_WHITE][sq] = 1'b1;
         file_q++;
      end
      if (last) close_record(ST_END);
   endtask

   task automatic push_char(input logic [7:0] c, input logic first, input logic last);
      char_item_type it;
      it.code  = c;
      it.first = first;
      it.last  = last;
      char_queue.push_back(it);
   endtask

   task automatic push_text(input string s, input bit with_last);
      int i;
      for (i = 0; i < s.len(); i++)
         push_char(s[i], i == 0, with_last && i == s.len() - 1);
      record_chars += s.len();
      record_total++;
   endtask

   // well-formed placement with random content, sometimes damaged
   task automatic push_random_record();
      logic [7:0] rec [$];
      int r;
      int fill;
      int run;
      int pos;
      int cut;
      int i;
      int mutate;
      int tail;
      logic [7:0] blank;
      mutate = $urandom_range(0, 11);
      tail   = $urandom_range(0, 9);
      for (r = 0; r < 8; r++) begin
         if (r > 0) rec.push_back(CH_SLASH);
         fill = 0;
         while (fill < 8) begin
            if ($urandom_range(1)) begin
               run = $urandom_range(1, 8 - fill);
               rec.push_back(8'(CH_ZERO + run));
               fill += run;
            end else begin
               rec.push_back(PIECE_LETTERS[$urandom_range(11)]);
               fill++;
            end
         end
      end
      // extra ranks past the first rank
      if (mutate == 3) begin
         repeat ($urandom_range(1, 2)) rec.push_back(CH_SLASH);
         if ($urandom_range(1)) rec.push_back(PIECE_LETTERS[$urandom_range(11)]);
         else rec.push_back(8'(CH_ZERO + $urandom_range(1, 8)));
      end
      blank = 8'($urandom_range(8, 13));
      if (blank == 8'd8) blank = CH_SPACE;
      rec.push_back(blank);
      if (mutate == 4) rec.push_back(CH_SPACE);
      else if (mutate == 5) rec.push_back(8'($urandom_range(255)));
      else rec.push_back($urandom_range(1) ? CH_BLACK : CH_WHITE);
      // single-character damage
      pos = $urandom_range(rec.size() - 1);
      if (mutate == 0) rec[pos] = 8'($urandom_range(255));
      else if (mutate == 1) rec.insert(pos, 8'($urandom_range(255)));
      else if (mutate == 2) rec.delete(pos);
      // early end of record
      if (tail == 6 || tail == 7) begin
         cut = $urandom_range(1, rec.size());
         while (rec.size() > cut) void'(rec.pop_back());
      end
      for (i = 0; i < rec.size(); i++)
         push_char(rec[i], i == 0, tail != 8 && i == rec.size() - 1);
      if (tail == 9) push_char(8'($urandom_range(255)), 1'b0, 1'b1);
      record_chars += rec.size();
      record_total++;
   endtask

   // driver: presents queued characters, predicts on each transfer
   always @(posedge clock) begin : drive_chars
      char_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_char(req_char_code, req_first_char, req_last_char);
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            if (char_queue.size() > 0 && !pause_now()) begin
               nxt = char_queue.pop_front();
               req_valid      <= 1'b1;
               req_char_code  <= nxt.code;
               req_first_char <= nxt.first;
               req_last_char  <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      error_count++;
      if (error_count <= 10)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endtask

   // monitor: random backpressure, field-by-field compare on each transfer
   always @(posedge clock) begin : watch_results
      res_type                     want;
      logic [NUM_BOARDS-1:0][63:0] got_boards;
      int                          i;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result, status %0d", rsp_status);
            end else begin
               want = expected_results.pop_front();
               got_boards = {rsp_black_board, rsp_white_board, rsp_king_board,
                             rsp_queen_board, rsp_rook_board, rsp_bishop_board,
                             rsp_knight_board, rsp_pawn_board, rsp_occupied_board};
               if (rsp_status !== want.status)
                  note_mismatch("status", 64'(want.status), 64'(rsp_status));
               if (rsp_side_to_move !== want.side)
                  note_mismatch("side_to_move", 64'(want.side), 64'(rsp_side_to_move));
               for (i = 0; i < NUM_BOARDS; i++)
                  if (got_boards[i] !== want.boards[i])
                     note_mismatch(board_name[i], want.boards[i], got_boards[i]);
               results_checked++;
            end
         end
         rsp_ready <= !pause_now();
      end
   end

   // stimulus and end of run
   initial begin
      // directed records: ignored input, lone first+last, each error code but a bad side letter
      push_char("x", 1'b0, 1'b1);
      push_char("K", 1'b1, 1'b1);
      record_total++;
      push_text("0", 1'b0);
      push_text("9", 1'b1);
      push_text("\200", 1'b0);
      push_text("\377", 1'b0);
      push_text("3/", 1'b0);
      push_text("54", 1'b0);
      push_text("8k", 1'b0);
      push_text(" ", 1'b0);
      push_text("7Q\n", 1'b1);
      push_text("pP", 1'b1);
      push_char("z", 1'b0, 1'b0);

      // random records, with occasional noise between them
      while (record_chars < 1200 || record_total < 40) begin
         push_random_record();
         if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3))
               push_char(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (char_queue.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (10) @(posedge clock);

      if (expected_results.size() != 0) begin
         error_count += expected_results.size();
         $display("%0d expected results never arrived", expected_results.size());
      end
      $display("Sent %0d characters in %0d records, checked %0d results",
               sent_count, record_total, results_checked);
      $display("Status codes exercised: %0d of 9", $countones(status_seen));
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // hard stop
   initial begin
      #10_000_000;
      $display("timeout waiting for results");
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
